// ----- sv/mcr_pkg.sv -----
// Shared types, widths and constants for the midpoint circle rasterizer.
package mcr_pkg;

  // Widths that follow from the supported radius and coordinate range
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 16;
  localparam int OFF_W       = RADIUS_BITS + 1;
  localparam int ERR_W       = RADIUS_BITS + 3;
  localparam int CALC_W      = ERR_W + 2;
  localparam int EXT_W       = (OFF_W > COORD_BITS) ? OFF_W : COORD_BITS;

  // Fixed field widths of the ports
  localparam int PIX_W     = 16;
  localparam int RAD_IN_W  = 10;
  localparam int RAD_EXT_W = (RAD_IN_W > RADIUS_BITS) ? RAD_IN_W : RADIUS_BITS;

  // Group of eight symmetric pixels per step
  localparam int GROUP_SIZE = 8;
  localparam int IDX_W      = $clog2(GROUP_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GROUP_SIZE - 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic                  op;
    logic signed [15:0]    center_x;
    logic signed [15:0]    center_y;
    logic [RAD_IN_W-1:0]   radius;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last;
    logic                    done_res;
  } out_item_t;

  // One octant group handed from front to back
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [OFF_W-1:0]      major;
    logic signed [OFF_W-1:0]      minor;
    logic                         done;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/mcr_front.sv -----
// Front end: accepts requests, holds circle state and advances the midpoint rule.
module mcr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcr_pkg::in_item_t in_data,
  input  mcr_pkg::q_stat_t  q_stat,
  output logic              push,
  output mcr_pkg::grp_t     push_data
);

  logic                                  running_r, running_nxt;
  logic signed [mcr_pkg::COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [mcr_pkg::OFF_W-1:0]      maj_r, maj_nxt, min_r, min_nxt;
  logic signed [mcr_pkg::ERR_W-1:0]      err_r, err_nxt;

  logic                                  accept;
  logic [mcr_pkg::RAD_EXT_W-1:0]         rad_ext;
  logic signed [mcr_pkg::CALC_W-1:0]     maj_x, min_x, err_x, mn, e1, mj_new, e_new;
  logic                                  step_down, done;

  // Take any request while the queue has room
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign rad_ext  = mcr_pkg::RAD_EXT_W'(in_data.radius);

  // Advance offsets and error term
  always_comb begin
    maj_x     = mcr_pkg::CALC_W'(maj_r);
    min_x     = mcr_pkg::CALC_W'(min_r);
    err_x     = mcr_pkg::CALC_W'(err_r);
    mn        = min_x + mcr_pkg::CALC_W'(1);
    e1        = err_x + (mn <<< 1) + mcr_pkg::CALC_W'(1);
    step_down = ((e1 <<< 1) + mcr_pkg::CALC_W'(1)) > (maj_x <<< 1);
    mj_new    = step_down ? (maj_x - mcr_pkg::CALC_W'(1)) : maj_x;
    e_new     = step_down ? (e1 - ((mj_new <<< 1) + mcr_pkg::CALC_W'(1))) : e1;
    done      = mj_new < mn;
  end

  // Emit a group for each step while a circle is active
  assign push              = accept && (in_data.op == mcr_pkg::OP_STEP) && running_r;
  assign push_data.cx      = cx_r;
  assign push_data.cy      = cy_r;
  assign push_data.major   = maj_r;
  assign push_data.minor   = min_r;
  assign push_data.done    = done;

  // Load on start, advance on step, hold otherwise
  always_comb begin
    running_nxt = running_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    maj_nxt     = maj_r;
    min_nxt     = min_r;
    err_nxt     = err_r;
    if (accept && in_data.op == mcr_pkg::OP_START) begin
      running_nxt = 1'b1;
      cx_nxt      = mcr_pkg::COORD_BITS'(in_data.center_x);
      cy_nxt      = mcr_pkg::COORD_BITS'(in_data.center_y);
      maj_nxt     = mcr_pkg::OFF_W'({1'b0, rad_ext[mcr_pkg::RADIUS_BITS-1:0]});
      min_nxt     = '0;
      err_nxt     = '0;
    end else if (push) begin
      running_nxt = !done;
      maj_nxt     = mcr_pkg::OFF_W'(mj_new);
      min_nxt     = mcr_pkg::OFF_W'(mn);
      err_nxt     = mcr_pkg::ERR_W'(e_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cx_r      <= '0;
      cy_r      <= '0;
      maj_r     <= '0;
      min_r     <= '0;
      err_r     <= '0;
    end else begin
      running_r <= running_nxt;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      maj_r     <= maj_nxt;
      min_r     <= min_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// ----- sv/mcr_queue.sv -----
// Short group queue between the front and back ends.
module mcr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcr_pkg::grp_t     push_data,
  input  logic              pop,
  output mcr_pkg::grp_t     pop_data,
  output mcr_pkg::q_stat_t  q_stat
);

  mcr_pkg::grp_t                 mem_r [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + mcr_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + mcr_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + mcr_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - mcr_pkg::QCNT_W'(1);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- sv/mcr_back.sv -----
// Back end: expands each group into eight symmetric pixels, one per cycle while out_ready allows.
module mcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mcr_pkg::q_stat_t   q_stat,
  input  mcr_pkg::grp_t      pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mcr_pkg::out_item_t out_data
);

  mcr_pkg::grp_t                       grp_r, grp_nxt;
  logic                                gvld_r, gvld_nxt;
  logic [mcr_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic                                ovld_r, ovld_nxt;
  mcr_pkg::out_item_t                  out_r, out_nxt;

  logic                                adv, swap, neg_x, neg_y;
  logic signed [mcr_pkg::OFF_W-1:0]    off_a, off_b;
  logic signed [mcr_pkg::EXT_W-1:0]    ext_a, ext_b, dx, dy;
  logic signed [mcr_pkg::COORD_BITS-1:0] sum_x, sum_y;

  // Move a pixel into the output register when it is free or draining
  assign adv = gvld_r && (!ovld_r || out_ready);
  assign pop = !q_stat.empty && (!gvld_r || (adv && idx_r == mcr_pkg::IDX_LAST));

  // Pick the octant: swap axes and signs from the pixel index
  always_comb begin
    swap  = idx_r[0] ^ idx_r[1];
    neg_x = idx_r[2] ^ idx_r[1];
    neg_y = idx_r[2];
    off_a = swap ? grp_r.minor : grp_r.major;
    off_b = swap ? grp_r.major : grp_r.minor;
    ext_a = mcr_pkg::EXT_W'(off_a);
    ext_b = mcr_pkg::EXT_W'(off_b);
    dx    = neg_x ? -ext_a : ext_a;
    dy    = neg_y ? -ext_b : ext_b;
    sum_x = grp_r.cx + dx[mcr_pkg::COORD_BITS-1:0];
    sum_y = grp_r.cy + dy[mcr_pkg::COORD_BITS-1:0];
  end

  // Sequence pixels, load groups, hold output until taken
  always_comb begin
    grp_nxt  = grp_r;
    gvld_nxt = gvld_r;
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r;
    out_nxt  = out_r;
    if (adv) begin
      ovld_nxt         = 1'b1;
      out_nxt.pixel_x  = mcr_pkg::PIX_W'(sum_x);
      out_nxt.pixel_y  = mcr_pkg::PIX_W'(sum_y);
      out_nxt.last     = (idx_r == mcr_pkg::IDX_LAST);
      out_nxt.done_res = grp_r.done;
      idx_nxt          = idx_r + mcr_pkg::IDX_W'(1);
      if (idx_r == mcr_pkg::IDX_LAST) begin
        gvld_nxt = 1'b0;
      end
    end else if (out_ready) begin
      ovld_nxt = 1'b0;
    end
    if (pop) begin
      grp_nxt  = pop_data;
      gvld_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvld_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      gvld_r <= gvld_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = out_r;

endmodule

// ----- sv/midpoint_circle_rasterizer.sv -----
// Top level of the midpoint circle rasterizer: front, group queue and pixel back end.
//
//   Channel | Handshake            | Payload             | Per request
//   --------+----------------------+---------------------+---------------------------
//   in      | in_valid / in_ready  | in_data (in_item_t) | start or step request
//   out     | out_valid/ out_ready | out_data(out_item_t)| eight pixels per live step
//
// A step request yields eight pixels at one pixel per cycle while out_ready is high,
// so the back end's pixel sequencer limits how fast live steps are taken. The first
// pixel of a step passes the queue entry, the group register and the output register.
// Reset (rst_n low, synchronous) clears the circle, queue and output register.
// The two-entry queue lets the front keep taking requests while the output stalls, until it is full.
module midpoint_circle_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcr_pkg::out_item_t out_data
);

  mcr_pkg::q_stat_t q_stat;
  logic             push, pop;
  mcr_pkg::grp_t    push_data, pop_data;

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Never push a group into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("group pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("group popped from empty queue");

  // A finished-circle pixel that is not last is followed by more of its group
  a_done_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.done_res && !out_data.last)
      |=> (!out_valid || out_data.done_res))
    else $error("done flag changed inside a group");
`endif

endmodule
